FILE: rtl/mp2d_pkg.sv
package mp2d_pkg;

   // Sample format and storage geometry
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_COLS    = 1024;
   localparam int COL_BITS    = $clog2(MAX_COLS);
   localparam int MAX_POOL    = 16;
   localparam int POOL_BITS   = $clog2(MAX_POOL);
   localparam int ROW_LIMIT   = 4096;
   localparam int ROW_BITS    = $clog2(ROW_LIMIT);

   // Register field widths
   localparam int PR_W = 5;
   localparam int PC_W = 5;
   localparam int IR_W = 13;
   localparam int IC_W = 11;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_POOL_ROWS  = 2'd0,
      REG_POOL_COLS  = 2'd1,
      REG_IMAGE_ROWS = 2'd2,
      REG_IMAGE_COLS = 2'd3
   } csr_index_type;

   // Effective (clamped) window and image sizes
   typedef struct packed {
      logic [PR_W-1:0] pool_rows;
      logic [PC_W-1:0] pool_cols;
      logic [IR_W-1:0] image_rows;
      logic [IC_W-1:0] image_cols;
   } geom_type;

   // One sample's work handed from the position tracker to the merge stage
   typedef struct packed {
      logic                close;      // sample closes the window columns
      logic                band_last;  // last row of the band: emit instead of store
      logic                merge;      // combine with stored band maximum
      logic                frame_end;
      logic [COL_BITS-1:0] slot;       // output column, band memory address
      sample_type          run;        // running max including this sample
   } stage_type;

endpackage

FILE: rtl/mp2d_csr.sv
module mp2d_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mp2d_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mp2d_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output mp2d_pkg::geom_type                  geom
);
   import mp2d_pkg::*;

   logic [PR_W-1:0] pool_rows_ff;
   logic [PC_W-1:0] pool_cols_ff;
   logic [IR_W-1:0] image_rows_ff;
   logic [IC_W-1:0] image_cols_ff;

   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_rows_ff  <= PR_W'(2);
         pool_cols_ff  <= PC_W'(2);
         image_rows_ff <= IR_W'(64);
         image_cols_ff <= IC_W'(64);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_POOL_ROWS:  pool_rows_ff  <= csr_wdata[PR_W-1:0];
            REG_POOL_COLS:  pool_cols_ff  <= csr_wdata[PC_W-1:0];
            REG_IMAGE_ROWS: image_rows_ff <= csr_wdata[IR_W-1:0];
            REG_IMAGE_COLS: image_cols_ff <= csr_wdata[IC_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero counts as one, large values saturate at the supported limit
   always_comb begin
      geom.pool_rows = pool_rows_ff;
      if (pool_rows_ff == '0)
         geom.pool_rows = PR_W'(1);
      else if (pool_rows_ff > PR_W'(MAX_POOL))
         geom.pool_rows = PR_W'(MAX_POOL);

      geom.pool_cols = pool_cols_ff;
      if (pool_cols_ff == '0)
         geom.pool_cols = PC_W'(1);
      else if (pool_cols_ff > PC_W'(MAX_POOL))
         geom.pool_cols = PC_W'(MAX_POOL);

      geom.image_rows = image_rows_ff;
      if (image_rows_ff == '0)
         geom.image_rows = IR_W'(1);
      else if (image_rows_ff > IR_W'(ROW_LIMIT))
         geom.image_rows = IR_W'(ROW_LIMIT);

      geom.image_cols = image_cols_ff;
      if (image_cols_ff == '0)
         geom.image_cols = IC_W'(1);
      else if (image_cols_ff > IC_W'(MAX_COLS))
         geom.image_cols = IC_W'(MAX_COLS);
   end

endmodule

FILE: rtl/mp2d_ctrl.sv
module mp2d_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  mp2d_pkg::sample_type sample,
   input  mp2d_pkg::geom_type   geom,
   output mp2d_pkg::stage_type  stage
);
   import mp2d_pkg::*;

   logic [ROW_BITS-1:0]  row_index_ff,   row_index_in;
   logic [COL_BITS-1:0]  col_index_ff,   col_index_in;
   logic [POOL_BITS-1:0] row_in_pool_ff, row_in_pool_in;
   logic [POOL_BITS-1:0] col_in_pool_ff, col_in_pool_in;
   logic [COL_BITS-1:0]  out_col_ff,     out_col_in;
   sample_type           run_max_ff,     run_max_in;
   sample_type           run_new;

   logic row_last, frame_last_row, band_last, win_col_last;

   // Position tests: "at or beyond the last" so a shrunk limit still closes
   assign row_last       = (IC_W'(col_index_ff) + IC_W'(1)) >= geom.image_cols;
   assign frame_last_row = (IR_W'(row_index_ff) + IR_W'(1)) >= geom.image_rows;
   assign band_last      = ((PR_W'(row_in_pool_ff) + PR_W'(1)) >= geom.pool_rows)
                           || frame_last_row;
   assign win_col_last   = ((PC_W'(col_in_pool_ff) + PC_W'(1)) >= geom.pool_cols)
                           || row_last;

   // Running max across the window columns of this row
   assign run_new = ((col_in_pool_ff == '0) || ($signed(sample) > $signed(run_max_ff)))
                    ? sample : run_max_ff;

   // Next position
   always_comb begin
      row_index_in   = row_index_ff;
      col_index_in   = col_index_ff;
      row_in_pool_in = row_in_pool_ff;
      col_in_pool_in = col_in_pool_ff;
      out_col_in     = out_col_ff;
      run_max_in     = run_max_ff;
      if (accept) begin
         run_max_in = run_new;
         if (win_col_last) begin
            out_col_in     = out_col_ff + COL_BITS'(1);
            col_in_pool_in = '0;
         end else begin
            col_in_pool_in = col_in_pool_ff + POOL_BITS'(1);
         end
         if (row_last) begin
            col_index_in   = '0;
            col_in_pool_in = '0;
            out_col_in     = '0;
            if (frame_last_row) begin
               row_index_in   = '0;
               row_in_pool_in = '0;
            end else begin
               row_index_in   = row_index_ff + ROW_BITS'(1);
               row_in_pool_in = band_last ? '0 : row_in_pool_ff + POOL_BITS'(1);
            end
         end else begin
            col_index_in = col_index_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_index_ff   <= '0;
         col_index_ff   <= '0;
         row_in_pool_ff <= '0;
         col_in_pool_ff <= '0;
         out_col_ff     <= '0;
         run_max_ff     <= SAMPLE_MIN;
      end else begin
         row_index_ff   <= row_index_in;
         col_index_ff   <= col_index_in;
         row_in_pool_ff <= row_in_pool_in;
         col_in_pool_ff <= col_in_pool_in;
         out_col_ff     <= out_col_in;
         run_max_ff     <= run_max_in;
      end
   end

   // Work for the merge stage; slot doubles as the band memory read address
   always_comb begin
      stage.close     = win_col_last;
      stage.band_last = band_last;
      stage.merge     = (row_in_pool_ff != '0);
      stage.frame_end = frame_last_row && row_last;
      stage.slot      = out_col_ff;
      stage.run       = run_new;
   end

   // Frame end rewinds every position counter
   a_frame_rewind: assert property (@(posedge clock) disable iff (reset)
      accept && stage.frame_end |=>
         row_index_ff == '0 && col_index_ff == '0 && row_in_pool_ff == '0
         && out_col_ff == '0)
      else $error("position not rewound after frame end");

   // A new row always starts at output column zero
   a_row_start: assert property (@(posedge clock) disable iff (reset)
      col_index_ff == '0 |-> out_col_ff == '0 && col_in_pool_ff == '0)
      else $error("row start with nonzero window position");

endmodule

FILE: rtl/mp2d_band.sv
module mp2d_band (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  mp2d_pkg::stage_type  stage_in,
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mp2d_pkg::sample_type rsp_pooled,
   output logic                 rsp_frame_end
);
   import mp2d_pkg::*;

   // Partial maximum per output column over the current band
   sample_type band_mem [MAX_COLS];

   sample_type rd_data_ff;
   sample_type fwd_data_ff;
   logic       fwd_ff;
   logic       s1_valid_ff;
   stage_type  s1_ff;
   logic       rsp_valid_ff;
   sample_type rsp_pooled_ff;
   logic       rsp_frame_end_ff;

   sample_type band_val;
   sample_type comb;
   logic       emit, out_free, s1_go, wr_en, fwd_hit;

   // Merge with the stored band maximum
   assign band_val = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign comb     = (s1_ff.merge && ($signed(band_val) > $signed(s1_ff.run)))
                     ? band_val : s1_ff.run;

   assign emit     = s1_ff.close && s1_ff.band_last;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_go    = s1_valid_ff && (!emit || out_free);
   assign wr_en    = s1_go && s1_ff.close && !s1_ff.band_last;
   assign busy     = s1_valid_ff && !s1_go;

   // Read and write back to the same column in one cycle: forward the new value
   assign fwd_hit  = accept && wr_en && (s1_ff.slot == stage_in.slot);

   // Band memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en)
         band_mem[s1_ff.slot] <= comb;
      if (accept)
         rd_data_ff <= band_mem[stage_in.slot];
   end

   // Merge stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= stage_in;
         fwd_data_ff <= comb;
      end
      if (s1_go && emit) begin
         rsp_pooled_ff    <= comb;
         rsp_frame_end_ff <= s1_ff.frame_end;
      end
   end

   // Stage and output beat control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= fwd_hit;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go && emit)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pooled    = rsp_pooled_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // Upstream never pushes into a blocked merge stage
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> !busy)
      else $error("sample accepted while merge stage blocked");

   // A pending result is never overwritten
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_pooled_ff))
      else $error("pending result lost");

   // Forwarding only follows a write-back to the column being read
   a_fwd_src: assert property (@(posedge clock) disable iff (reset)
      $rose(fwd_ff) |-> $past(wr_en) && $past(accept))
      else $error("forward without matching write-back");

endmodule

FILE: rtl/max_pool_2d_stream_top.sv
// Streaming 2-D max pooling. Samples arrive in raster order, at most one beat
// per clock; the block never stalls on its own and only backs up when the
// result side holds rsp_stall with a result already waiting. Each pool_rows x
// pool_cols window (non-overlapping, partial windows at the right and bottom
// edges kept) yields one pooled beat, registered in the merge stage and then in
// the output register; rsp_frame_end marks the last one of the frame. A 1024 x 16
// band memory holds the partial column maximum of the current band of pool
// rows: it is read when a sample is taken and written back by the merge
// stage on the next clock, with a bypass when that same column is read again
// at once. The memory needs no clearing pass after reset, since the first row
// of each band overwrites its entries. Configuration may be written only
// while no sample is in flight; new sizes take effect at the next sample.
module max_pool_2d_stream_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mp2d_pkg::sample_type                req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mp2d_pkg::sample_type                rsp_pooled,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mp2d_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mp2d_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mp2d_pkg::*;

   geom_type  geom;
   stage_type stage;
   logic      busy;
   logic      accept;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   mp2d_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   mp2d_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (req_sample),
      .geom   (geom),
      .stage  (stage)
   );

   mp2d_band u_band (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .stage_in      (stage),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pooled    (rsp_pooled),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
